/* rtl/rotation_matrix_to_quaternion_unit_assert.svh */
// Assertion macros for the rotation matrix to quaternion unit.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// Checked only outside reset.
`define RMQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, constants and shared types of the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int GUARD_BITS = 10;
   localparam int ENT_W      = 16;               // matrix entry
   localparam int C_W        = 18;               // signed vector component
   localparam int MAG_W      = 17;               // component magnitude
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int RAD_W      = SUM_W + 2 * GUARD_BITS;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 4;
   localparam int NUM_W      = MAG_W + FRAC_BITS + GUARD_BITS + 1;
   localparam int Q_W        = 17;               // quotient bits computed
   localparam int DREM_W     = ROOT_W + 1;
   localparam int W_W        = 15;
   localparam int Q_OUT_W    = 16;
   localparam int ONE_VAL    = 1 << FRAC_BITS;
   localparam int LIM_VAL    = (ONE_VAL > 32767) ? 32767 : ONE_VAL;

   // stage positions in the valid chain
   localparam int ST_ROOT    = 3;                // radicand registered
   localparam int ST_DIV     = ST_ROOT + ROOT_W + 1;
   localparam int ST_QUOT    = ST_DIV + Q_W;
   localparam int NUM_STAGES = ST_QUOT + 2;

   typedef struct packed {
      logic [3:0] neg;
      logic       degen;
   } aux_type;

endpackage

/* rtl/rmq_div_lane.sv */
// ----------------------------------------------------------------------------
// rmq_div_lane
// Pipelined restoring divider: rounded (mag << 24) / den, one bit per stage.
// ----------------------------------------------------------------------------
module rmq_div_lane (
   input  logic                        clock,
   input  logic                        en,
   input  logic [rmq_pkg::MAG_W-1:0]   mag_in,
   input  logic [rmq_pkg::ROOT_W-1:0]  den_in,
   output logic [rmq_pkg::Q_W-1:0]     quot_out
);
   import rmq_pkg::*;

   logic [NUM_W-1:0]  num;
   logic [DREM_W-1:0] rem_ff [0:Q_W];
   logic [Q_W-1:0]    low_ff [0:Q_W];
   logic [Q_W-1:0]    quot_ff [0:Q_W];
   logic [ROOT_W-1:0] den_ff [0:Q_W];

   // numerator plus half the divisor for round half up
   assign num = ({{(NUM_W-MAG_W){1'b0}}, mag_in} << (FRAC_BITS + GUARD_BITS))
              + {{(NUM_W-ROOT_W+1){1'b0}}, den_in[ROOT_W-1:1]};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DREM_W'(num[NUM_W-1:Q_W]);
         low_ff[0]  <= num[Q_W-1:0];
         quot_ff[0] <= '0;
         den_ff[0]  <= den_in;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [DREM_W-1:0] rsh;
      logic              take;
      assign rsh  = {rem_ff[k][DREM_W-2:0], low_ff[k][Q_W-1]};
      assign take = rsh >= {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= take ? rsh - {1'b0, den_ff[k]} : rsh;
            low_ff[k+1]  <= {low_ff[k][Q_W-2:0], 1'b0};
            quot_ff[k+1] <= {quot_ff[k][Q_W-2:0], take};
            den_ff[k+1]  <= den_ff[k];
         end
      end
   end

   assign quot_out = quot_ff[Q_W];

endmodule

/* rtl/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Rotation matrix (Q2.14) to unit quaternion, Shepperd branch selection.
// ----------------------------------------------------------------------------
// Input channel req_: nine signed Q2.14 matrix entries per word.
// Result channel rsp_: w (unsigned Q1.14, never negative), x, y, z in Q2.14
// and a degenerate flag; a degenerate word carries the identity quaternion.
// Throughput: one word per cycle unless stalled. The pipeline has 51
// stages: branch select, magnitudes, squares, norm sum, 28 one-bit square
// root steps, divider setup, 17 one-bit divide steps in four parallel lanes,
// and the output register.
// Stall: all stages advance together. When the result is held and not taken,
// the whole pipeline freezes and req_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block accepts input on the next cycle.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [rmq_pkg::ENT_W-1:0]  req_e00,
   input  logic signed [rmq_pkg::ENT_W-1:0]  req_e01,
   input  logic signed [rmq_pkg::ENT_W-1:0]  req_e02,
   input  logic signed [rmq_pkg::ENT_W-1:0]  req_e10,
   input  logic signed [rmq_pkg::ENT_W-1:0]  req_e11,
   input  logic signed [rmq_pkg::ENT_W-1:0]  req_e12,
   input  logic signed [rmq_pkg::ENT_W-1:0]  req_e20,
   input  logic signed [rmq_pkg::ENT_W-1:0]  req_e21,
   input  logic signed [rmq_pkg::ENT_W-1:0]  req_e22,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rmq_pkg::W_W-1:0]           rsp_quat_w,
   output logic signed [rmq_pkg::Q_OUT_W-1:0] rsp_quat_x,
   output logic signed [rmq_pkg::Q_OUT_W-1:0] rsp_quat_y,
   output logic signed [rmq_pkg::Q_OUT_W-1:0] rsp_quat_z,
   output logic                              rsp_degenerate
);
   import rmq_pkg::*;

   logic en;
   logic [NUM_STAGES-1:0] vld_ff;

   logic signed [C_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic signed [C_W-1:0] trace, arg;
   logic signed [C_W-1:0] c_in [4];
   logic signed [C_W-1:0] c_ff [4];
   logic                  dg1_ff;

   logic [MAG_W-1:0] mag_ff [1:ST_DIV-1][4];
   aux_type          aux_ff [1:ST_QUOT];
   logic [SQ_W-1:0]  sq_ff [4];

   logic [REM_W-1:0]  rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [0:ROOT_W];

   logic [Q_W-1:0]    quot [4];
   logic [W_W-1:0]    qm [4];

   assign en        = !vld_ff[NUM_STAGES-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   // branch select and integer vector
   assign m00 = C_W'(req_e00);
   assign m01 = C_W'(req_e01);
   assign m02 = C_W'(req_e02);
   assign m10 = C_W'(req_e10);
   assign m11 = C_W'(req_e11);
   assign m12 = C_W'(req_e12);
   assign m20 = C_W'(req_e20);
   assign m21 = C_W'(req_e21);
   assign m22 = C_W'(req_e22);
   assign trace = m00 + m11 + m22;

   always_comb begin
      if (trace > 0) begin
         arg     = trace + C_W'(ONE_VAL);
         c_in[0] = arg;
         c_in[1] = m21 - m12;
         c_in[2] = m02 - m20;
         c_in[3] = m10 - m01;
      end else if (m00 > m11 && m00 > m22) begin
         arg     = C_W'(ONE_VAL) + m00 - m11 - m22;
         c_in[0] = m21 - m12;
         c_in[1] = arg;
         c_in[2] = m01 + m10;
         c_in[3] = m02 + m20;
      end else if (m11 > m22) begin
         arg     = C_W'(ONE_VAL) + m11 - m00 - m22;
         c_in[0] = m02 - m20;
         c_in[1] = m01 + m10;
         c_in[2] = arg;
         c_in[3] = m12 + m21;
      end else begin
         arg     = C_W'(ONE_VAL) + m22 - m00 - m11;
         c_in[0] = m10 - m01;
         c_in[1] = m02 + m20;
         c_in[2] = m12 + m21;
         c_in[3] = arg;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff   <= c_in;
         dg1_ff <= arg <= 0;
      end
   end

   // magnitudes with signs relative to w
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            mag_ff[1][k]  <= c_ff[k][C_W-1] ? MAG_W'(-c_ff[k]) : MAG_W'(c_ff[k]);
            aux_ff[1].neg[k] <= c_ff[k][C_W-1] != c_ff[0][C_W-1];
         end
         aux_ff[1].degen <= dg1_ff;
      end
   end

   for (genvar i = 2; i < ST_DIV; i++) begin : g_mag
      always_ff @(posedge clock) begin
         if (en) mag_ff[i] <= mag_ff[i-1];
      end
   end

   for (genvar i = 2; i <= ST_QUOT; i++) begin : g_aux
      always_ff @(posedge clock) begin
         if (en) aux_ff[i] <= aux_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            sq_ff[k] <= mag_ff[1][k] * mag_ff[1][k];
         end
         rad_ff[0]  <= {SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2])
                        + SUM_W'(sq_ff[3]), {(2*GUARD_BITS){1'b0}}};
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      logic [REM_W-1:0] rsh, trial;
      logic             take;
      assign rsh   = {rem_ff[k][REM_W-3:0], rad_ff[k][RAD_W-1:RAD_W-2]};
      assign trial = {2'b00, root_ff[k], 2'b01};
      assign take  = rsh >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= take ? rsh - trial : rsh;
            root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], take};
            rad_ff[k+1]  <= {rad_ff[k][RAD_W-3:0], 2'b00};
         end
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_div
      rmq_div_lane u_div (
         .clock    (clock),
         .en       (en),
         .mag_in   (mag_ff[ST_DIV-1][k]),
         .den_in   (root_ff[ROOT_W]),
         .quot_out (quot[k])
      );
      assign qm[k] = (quot[k] > Q_W'(LIM_VAL)) ? W_W'(LIM_VAL) : quot[k][W_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (aux_ff[ST_QUOT].degen) begin
            rsp_quat_w <= W_W'(LIM_VAL);
            rsp_quat_x <= '0;
            rsp_quat_y <= '0;
            rsp_quat_z <= '0;
         end else begin
            rsp_quat_w <= qm[0];
            rsp_quat_x <= aux_ff[ST_QUOT].neg[1] ? -Q_OUT_W'(qm[1]) : Q_OUT_W'(qm[1]);
            rsp_quat_y <= aux_ff[ST_QUOT].neg[2] ? -Q_OUT_W'(qm[2]) : Q_OUT_W'(qm[2]);
            rsp_quat_z <= aux_ff[ST_QUOT].neg[3] ? -Q_OUT_W'(qm[3]) : Q_OUT_W'(qm[3]);
         end
         rsp_degenerate <= aux_ff[ST_QUOT].degen;
      end
   end

endmodule

/* rtl/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the matrix to quaternion unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rmq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rmq_pkg::W_W-1:0]            rsp_quat_w,
   input logic signed [rmq_pkg::Q_OUT_W-1:0] rsp_quat_x,
   input logic signed [rmq_pkg::Q_OUT_W-1:0] rsp_quat_y,
   input logic signed [rmq_pkg::Q_OUT_W-1:0] rsp_quat_z,
   input logic                               rsp_degenerate
);
   import rmq_pkg::*;

   logic ident;
   logic w_ok, x_ok, y_ok, z_ok;

   assign ident = rsp_quat_w == W_W'(LIM_VAL) && rsp_quat_x == 0 && rsp_quat_y == 0
                  && rsp_quat_z == 0;
   assign w_ok  = rsp_quat_w <= W_W'(LIM_VAL);
   assign x_ok  = rsp_quat_x <= Q_OUT_W'(LIM_VAL) && rsp_quat_x >= -Q_OUT_W'(LIM_VAL);
   assign y_ok  = rsp_quat_y <= Q_OUT_W'(LIM_VAL) && rsp_quat_y >= -Q_OUT_W'(LIM_VAL);
   assign z_ok  = rsp_quat_z <= Q_OUT_W'(LIM_VAL) && rsp_quat_z >= -Q_OUT_W'(LIM_VAL);

   `RMQ_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "word after reset")
   `RMQ_ASSERT(a_degen_identity, rsp_valid && rsp_degenerate |-> ident, "degenerate not identity")
   `RMQ_ASSERT(a_range, rsp_valid |-> w_ok && x_ok && y_ok && z_ok, "component out of range")
   `RMQ_ASSERT(a_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_w) && $stable(rsp_quat_x) && $stable(rsp_degenerate), "stalled word changed")

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);
